FILE: rtl/core/apf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apf_pkg - shared types and constants of the APRS position formatter
// Pipeline depth, character codes, part codes and the per-coordinate
// character bundle that the arithmetic pipe hands to the serializer.
// ----------------------------------------------------------------------------
package apf_pkg;

  // register stages of one coordinate pipe
  localparam int PIPE_DEPTH   = 9;

  // characters of one fix
  localparam int MAX_CHARS    = 22;
  localparam int NORMAL_CHARS = 17;
  localparam int CNT_W        = $clog2(MAX_CHARS + 1);

  // part codes
  localparam logic [1:0] PART_LAT = 2'd0;
  localparam logic [1:0] PART_LNG = 2'd1;
  localparam logic [1:0] PART_DAO = 2'd2;

  // ASCII codes
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_DOT  = 8'h2E;
  localparam logic [7:0] CH_BANG = 8'h21;
  localparam logic [7:0] CH_LOW_W = 8'h77;
  localparam logic [7:0] CH_N    = 8'h4E;
  localparam logic [7:0] CH_S    = 8'h53;
  localparam logic [7:0] CH_E    = 8'h45;
  localparam logic [7:0] CH_W    = 8'h57;
  localparam logic [7:0] DAO_OFFSET = 8'd33;

  // reciprocals: floor(2^37/125), floor(2^34/1000)
  localparam logic [30:0] RECIP_125  = 31'd1099511627;
  localparam logic [24:0] RECIP_1000 = 25'd17179869;

  // rounding guards on minutes * 100000
  localparam logic [23:0] GUARD_NORMAL  = 24'd5999500;
  localparam logic [23:0] GUARD_PRECISE = 24'd5999995;

  // formatted characters of one coordinate
  typedef struct packed {
    logic [7:0] deg_h;
    logic [7:0] deg_t;
    logic [7:0] deg_o;
    logic [7:0] min_t;
    logic [7:0] min_o;
    logic [7:0] frac_t;
    logic [7:0] frac_o;
    logic [7:0] dao;
    logic       hemi;
    logic       precise;
  } coord_chars_t;

endpackage

FILE: rtl/core/aprs_position_formatter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aprs_position_formatter - APRS uncompressed position text with DAO
// Formats one position fix as ASCII: DDMM.mmN/S, DDDMM.mmE/W and, in
// precise mode, the extension !wXY!.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one fix per word, taken when in_valid is high and
//   in_stall is low. Output channel (out_*): one character per word with its
//   part code; out_last marks the final character of the fix.
//   Config channel (cfg_*): cfg_precise_mode, always ready; write it only
//   while no fix is in flight.
//   A fix passes the 9 arithmetic stages and then the load of the output
//   shift line before its first character shows up.
//   Throughput: one character per cycle while out_stall is low, set by the
//   output shift line; a fix is 17 characters in normal mode, 22 in precise.
//   Up to 9 further fixes queue in the arithmetic pipe meanwhile, one per
//   cycle, and fixes keep entering as long as the pipe has a free stage.
//   Reset (rst_n low, synchronous) drops every fix in flight and clears
//   precise mode. A receiver stall holds the current character; the pipe
//   keeps collapsing bubbles and raises in_stall once every stage is full.
// ----------------------------------------------------------------------------
module aprs_position_formatter (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [6:0]  in_lat_degrees,
  input  logic        in_lat_south,
  input  logic [29:0] in_lat_billionths,
  input  logic [7:0]  in_lng_degrees,
  input  logic        in_lng_west,
  input  logic [29:0] in_lng_billionths,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_character,
  output logic [1:0]  out_part,
  output logic        out_last,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_precise_mode
);
  import apf_pkg::*;

  logic                  precise_r, precise_nxt;
  logic [PIPE_DEPTH-1:0] vld_r, vld_nxt;
  logic [PIPE_DEPTH-1:0] stage_en;
  logic                  load_ready;
  coord_chars_t          lat_chars, lng_chars;

  // config register is always writable
  assign cfg_ready = 1'b1;

  always_comb begin
    precise_nxt = precise_r;
    if (cfg_valid && cfg_ready) begin
      precise_nxt = cfg_precise_mode;
    end
  end

  // stage enables: a stage advances when it holds a bubble or the stage
  // after it advances; the last stage advances into the shift line
  always_comb begin
    stage_en[PIPE_DEPTH-1] = !vld_r[PIPE_DEPTH-1] || load_ready;
    for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
      stage_en[k] = !vld_r[k] || stage_en[k+1];
    end
  end

  assign in_stall = !stage_en[0];

  // valid bits travel with the data
  always_comb begin
    vld_nxt = vld_r;
    if (stage_en[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int k = 1; k < PIPE_DEPTH; k++) begin
      if (stage_en[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      precise_r <= 1'b0;
      vld_r     <= '0;
    end else begin
      precise_r <= precise_nxt;
      vld_r     <= vld_nxt;
    end
  end

  // latitude: degrees above 99 drop the hundreds digit downstream
  apf_coord_pipe u_lat_pipe (
    .clk        (clk),
    .stage_en   (stage_en),
    .deg        ({1'b0, in_lat_degrees}),
    .hemi       (in_lat_south),
    .billionths (in_lat_billionths),
    .precise    (precise_r),
    .chars      (lat_chars)
  );

  apf_coord_pipe u_lng_pipe (
    .clk        (clk),
    .stage_en   (stage_en),
    .deg        (in_lng_degrees),
    .hemi       (in_lng_west),
    .billionths (in_lng_billionths),
    .precise    (precise_r),
    .chars      (lng_chars)
  );

  apf_serializer u_serializer (
    .clk           (clk),
    .rst_n         (rst_n),
    .load_valid    (vld_r[PIPE_DEPTH-1]),
    .load_ready    (load_ready),
    .lat           (lat_chars),
    .lng           (lng_chars),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .out_part      (out_part),
    .out_last      (out_last)
  );

endmodule

FILE: rtl/core/apf_coord_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apf_coord_pipe - minutes arithmetic and digit split for one coordinate
// Nine register stages from billionths of a degree to ASCII digits, each
// stage loaded by its own enable from the pipeline control.
// ----------------------------------------------------------------------------
module apf_coord_pipe (
  input  logic                               clk,
  input  logic [apf_pkg::PIPE_DEPTH-1:0]     stage_en,
  input  logic [7:0]                         deg,
  input  logic                               hemi,
  input  logic [29:0]                        billionths,
  input  logic                               precise,
  output apf_pkg::coord_chars_t              chars
);
  import apf_pkg::*;

  typedef struct packed {
    logic [1:0] deg_h;
    logic [3:0] deg_t;
    logic [3:0] deg_o;
    logic       hemi;
    logic       precise;
  } side_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    digit_char = {4'd0, d} + CH_ZERO;
  endfunction

  function automatic logic [3:0] tens_of(input logic [6:0] v);
    logic [14:0] p;
    p = {8'd0, v} * 15'd205;
    tens_of = p[14:11];
  endfunction

  function automatic logic [3:0] ones_of(input logic [6:0] v, input logic [3:0] t);
    logic [6:0] r;
    r = v - ({3'd0, t} * 7'd10);
    ones_of = r[3:0];
  endfunction

  side_t        side_r [PIPE_DEPTH-1];
  side_t        side_nxt;

  logic [31:0]  triple;
  logic [29:0]  u1_r, u1_nxt, u2_r;
  logic [1:0]   dh;
  logic [7:0]   drem8;
  logic [6:0]   drem;
  logic [3:0]   dt;

  logic [60:0]  prod2;
  logic [23:0]  q2_r, q2_nxt;

  logic [30:0]  mul3, rem3;
  logic [23:0]  s3_r, s3_nxt;

  logic [48:0]  prod4;
  logic [23:0]  s4_r;
  logic [14:0]  a4_r, a4_nxt;

  logic [24:0]  mul5, rem5, rem5_adj;
  logic [23:0]  s5_r;
  logic [14:0]  a5_r, a5_nxt;
  logic [9:0]   b5_r, b5_nxt;

  logic [17:0]  prod6;
  logic [6:0]   c6;
  logic [9:0]   tmp6;
  logic [3:0]   d6;
  logic [14:0]  a6_r;
  logic [9:0]   b6_r;
  logic         rnd6_r, rnd6_nxt;

  logic [10:0]  add7, add7_adj;
  logic [14:0]  a7_r, a7_nxt;
  logic [9:0]   b7_r, b7_nxt;

  logic [27:0]  prod8;
  logic [14:0]  tmp8;
  logic [21:0]  prod8b;
  logic [6:0]   h8_r, h8_nxt, l8_r, l8_nxt;
  logic [7:0]   dao8_r, dao8_nxt;

  logic [3:0]   ht9, lt9;
  coord_chars_t chars_r, chars_nxt;

  // stage 1: scale by 3/4, split degrees into digits
  always_comb begin
    triple = {2'b00, billionths} + {1'b0, billionths, 1'b0};
    u1_nxt = triple[31:2];
    if (deg >= 8'd200) begin
      dh = 2'd2;
    end else if (deg >= 8'd100) begin
      dh = 2'd1;
    end else begin
      dh = 2'd0;
    end
    drem8 = deg - ({6'd0, dh} * 8'd100);
    drem  = drem8[6:0];
    dt    = tens_of(drem);
    side_nxt.deg_h   = dh;
    side_nxt.deg_t   = dt;
    side_nxt.deg_o   = ones_of(drem, dt);
    side_nxt.hemi    = hemi;
    side_nxt.precise = precise;
  end

  // stage 2: quotient estimate of u / 125
  always_comb begin
    prod2  = {31'd0, u1_r} * {30'd0, RECIP_125};
    q2_nxt = prod2[60:37];
  end

  // stage 3: correct the estimate by one
  always_comb begin
    mul3   = {7'd0, q2_r} * 31'd125;
    rem3   = {1'b0, u2_r} - mul3;
    s3_nxt = q2_r + {23'd0, (rem3 >= 31'd125)};
  end

  // stage 4: thousands estimate
  always_comb begin
    prod4  = {25'd0, s3_r} * {24'd0, RECIP_1000};
    a4_nxt = prod4[48:34];
  end

  // stage 5: correct thousands, form the low three decimals
  always_comb begin
    mul5     = {10'd0, a4_r} * 25'd1000;
    rem5     = {1'b0, s4_r} - mul5;
    rem5_adj = rem5 - 25'd1000;
    if (rem5 >= 25'd1000) begin
      a5_nxt = a4_r + 15'd1;
      b5_nxt = rem5_adj[9:0];
    end else begin
      a5_nxt = a4_r;
      b5_nxt = rem5[9:0];
    end
  end

  // stage 6: decide rounding
  always_comb begin
    prod6 = {8'd0, b5_r} * 18'd205;
    c6    = prod6[17:11];
    tmp6  = b5_r - ({3'd0, c6} * 10'd10);
    d6    = tmp6[3:0];
    if (side_r[4].precise) begin
      rnd6_nxt = (d6 >= 4'd5) && (s5_r < GUARD_PRECISE);
    end else begin
      rnd6_nxt = (b5_r >= 10'd500) && (s5_r < GUARD_NORMAL);
    end
  end

  // stage 7: apply rounding, carry into thousands
  always_comb begin
    add7 = {1'b0, b6_r};
    if (rnd6_r) begin
      add7 = {1'b0, b6_r} + (side_r[5].precise ? 11'd5 : 11'd500);
    end
    add7_adj = add7 - 11'd1000;
    if (add7 >= 11'd1000) begin
      a7_nxt = a6_r + 15'd1;
      b7_nxt = add7_adj[9:0];
    end else begin
      a7_nxt = a6_r;
      b7_nxt = add7[9:0];
    end
  end

  // stage 8: whole minutes, hundredths, base91 DAO character
  always_comb begin
    prod8    = {13'd0, a7_r} * 28'd5243;
    h8_nxt   = prod8[25:19];
    tmp8     = a7_r - ({8'd0, h8_nxt} * 15'd100);
    l8_nxt   = tmp8[6:0];
    prod8b   = {12'd0, b7_r} * 22'd2979;
    dao8_nxt = {1'b0, prod8b[21:15]} + DAO_OFFSET;
  end

  // stage 9: ASCII digits
  always_comb begin
    ht9 = tens_of(h8_r);
    lt9 = tens_of(l8_r);
    chars_nxt.deg_h   = digit_char({2'd0, side_r[7].deg_h});
    chars_nxt.deg_t   = digit_char(side_r[7].deg_t);
    chars_nxt.deg_o   = digit_char(side_r[7].deg_o);
    chars_nxt.min_t   = digit_char(ht9);
    chars_nxt.min_o   = digit_char(ones_of(h8_r, ht9));
    chars_nxt.frac_t  = digit_char(lt9);
    chars_nxt.frac_o  = digit_char(ones_of(l8_r, lt9));
    chars_nxt.dao     = dao8_r;
    chars_nxt.hemi    = side_r[7].hemi;
    chars_nxt.precise = side_r[7].precise;
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      u1_r      <= u1_nxt;
      side_r[0] <= side_nxt;
    end
    for (int k = 1; k < PIPE_DEPTH - 1; k++) begin
      if (stage_en[k]) begin
        side_r[k] <= side_r[k-1];
      end
    end
    if (stage_en[1]) begin
      u2_r <= u1_r;
      q2_r <= q2_nxt;
    end
    if (stage_en[2]) begin
      s3_r <= s3_nxt;
    end
    if (stage_en[3]) begin
      s4_r <= s3_r;
      a4_r <= a4_nxt;
    end
    if (stage_en[4]) begin
      s5_r <= s4_r;
      a5_r <= a5_nxt;
      b5_r <= b5_nxt;
    end
    if (stage_en[5]) begin
      a6_r   <= a5_r;
      b6_r   <= b5_r;
      rnd6_r <= rnd6_nxt;
    end
    if (stage_en[6]) begin
      a7_r <= a7_nxt;
      b7_r <= b7_nxt;
    end
    if (stage_en[7]) begin
      h8_r   <= h8_nxt;
      l8_r   <= l8_nxt;
      dao8_r <= dao8_nxt;
    end
    if (stage_en[8]) begin
      chars_r <= chars_nxt;
    end
  end

  assign chars = chars_r;

endmodule

FILE: rtl/core/apf_serializer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apf_serializer - one fix into a stream of characters
// Loads both coordinates' characters into a shift line and sends them one
// word per cycle unless stalled; reloads in the cycle the last one leaves.
// ----------------------------------------------------------------------------
module apf_serializer (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load_valid,
  output logic                  load_ready,
  input  apf_pkg::coord_chars_t lat,
  input  apf_pkg::coord_chars_t lng,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_character,
  output logic [1:0]            out_part,
  output logic                  out_last
);
  import apf_pkg::*;

  logic [7:0]       chr_r [MAX_CHARS];
  logic [1:0]       prt_r [MAX_CHARS];
  logic [7:0]       ld_chr [MAX_CHARS];
  logic [1:0]       ld_prt [MAX_CHARS];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             take, load;

  assign take       = out_valid && !out_stall;
  assign load_ready = (cnt_r == '0) || ((cnt_r == CNT_W'(1)) && !out_stall);
  assign load       = load_valid && load_ready;

  always_comb begin
    ld_chr[0]  = lat.deg_t;
    ld_chr[1]  = lat.deg_o;
    ld_chr[2]  = lat.min_t;
    ld_chr[3]  = lat.min_o;
    ld_chr[4]  = CH_DOT;
    ld_chr[5]  = lat.frac_t;
    ld_chr[6]  = lat.frac_o;
    ld_chr[7]  = lat.hemi ? CH_S : CH_N;
    ld_chr[8]  = lng.deg_h;
    ld_chr[9]  = lng.deg_t;
    ld_chr[10] = lng.deg_o;
    ld_chr[11] = lng.min_t;
    ld_chr[12] = lng.min_o;
    ld_chr[13] = CH_DOT;
    ld_chr[14] = lng.frac_t;
    ld_chr[15] = lng.frac_o;
    ld_chr[16] = lng.hemi ? CH_W : CH_E;
    ld_chr[17] = CH_BANG;
    ld_chr[18] = CH_LOW_W;
    ld_chr[19] = lat.dao;
    ld_chr[20] = lng.dao;
    ld_chr[21] = CH_BANG;
    for (int k = 0; k < MAX_CHARS; k++) begin
      if (k < 8) begin
        ld_prt[k] = PART_LAT;
      end else if (k < NORMAL_CHARS) begin
        ld_prt[k] = PART_LNG;
      end else begin
        ld_prt[k] = PART_DAO;
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (load) begin
      cnt_nxt = lat.precise ? CNT_W'(MAX_CHARS) : CNT_W'(NORMAL_CHARS);
    end else if (take) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // shift line: load a fix, advance one word per accepted character
  always_ff @(posedge clk) begin
    if (load) begin
      for (int k = 0; k < MAX_CHARS; k++) begin
        chr_r[k] <= ld_chr[k];
        prt_r[k] <= ld_prt[k];
      end
    end else if (take) begin
      for (int k = 0; k < MAX_CHARS - 1; k++) begin
        chr_r[k] <= chr_r[k+1];
        prt_r[k] <= prt_r[k+1];
      end
    end
  end

  assign out_valid     = (cnt_r != '0);
  assign out_character = chr_r[0];
  assign out_part      = prt_r[0];
  assign out_last      = (cnt_r == CNT_W'(1));

endmodule

FILE: rtl/core/apf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apf_checker - port-level checks of the position formatter
// Watches the result channel for stream framing and hold behavior.
// ----------------------------------------------------------------------------
module apf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_character,
  input logic [1:0] out_part,
  input logic       out_last
);
  import apf_pkg::*;

  // nothing leaves right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // a fix streams without gaps until its last character
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> out_valid)
    else $error("gap inside a fix");

  // a fix ends on the longitude letter or on the closing bang of DAO
  a_last_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |->
      (out_part == PART_LNG && (out_character == CH_E || out_character == CH_W)) ||
      (out_part == PART_DAO && out_character == CH_BANG))
    else $error("fix ends on a wrong character");

  // longitude never goes back to latitude within a fix
  a_part_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last && out_part == PART_LNG |=>
      out_part != PART_LAT)
    else $error("part order broken");

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      out_valid && $stable(out_character) && $stable(out_part) && $stable(out_last))
    else $error("stalled word changed");

endmodule

bind aprs_position_formatter apf_checker u_apf_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_character (out_character),
  .out_part      (out_part),
  .out_last      (out_last)
);
